[hw/rtl/edsa_pkg.sv]
// Package for the dual-setpoint encoder adjuster: widths, register indexes,
// reset values and the shared structs. No dependencies.
`default_nettype none

package edsa_pkg;

    localparam int VALUE_W    = 9;
    localparam int STEP_W     = 5;
    localparam int GAP_W      = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = VALUE_W;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_MIN = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_MAX = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_GAP = 4'd3;

    // Reset values
    localparam logic [STEP_W-1:0]  RST_STEP_SIZE = STEP_W'(5);
    localparam logic [VALUE_W-1:0] RST_COUNT_MIN = VALUE_W'(5);
    localparam logic [VALUE_W-1:0] RST_COUNT_MAX = VALUE_W'(295);
    localparam logic [GAP_W-1:0]   RST_ORDER_GAP = GAP_W'(5);
    localparam logic [VALUE_W-1:0] RST_WORK      = VALUE_W'(250);
    localparam logic [VALUE_W-1:0] RST_LOWER     = VALUE_W'(200);
    localparam logic [VALUE_W-1:0] RST_UPPER     = VALUE_W'(250);

    typedef struct packed {
        logic [STEP_W-1:0]  step_size;
        logic [VALUE_W-1:0] count_min;
        logic [VALUE_W-1:0] count_max;
        logic [GAP_W-1:0]   order_gap;
    } cfg_t;

    typedef struct packed {
        logic line_a;
        logic line_b;
        logic button_level;
    } sample_t;

    typedef struct packed {
        logic [VALUE_W-1:0] work_count;
        logic               step_lockout;
        logic               button_prev;
        logic               edit_upper;
        logic [VALUE_W-1:0] lower_value;
        logic [VALUE_W-1:0] upper_value;
    } state_t;

endpackage

`default_nettype wire

[hw/rtl/edsa_if.sv]
// Valid/ready channel interfaces for poll samples and setpoint results.
// Depends on edsa_pkg for the value width.
`default_nettype none

interface edsa_poll_if;
    logic valid;
    logic ready;
    logic line_a;
    logic line_b;
    logic button_level;

    modport source (output valid, line_a, line_b, button_level, input ready);
    modport sink   (input valid, line_a, line_b, button_level, output ready);
endinterface

interface edsa_report_if;
    import edsa_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] lower_setpoint;
    logic [VALUE_W-1:0] upper_setpoint;
    logic               upper_active;

    modport source (output valid, lower_setpoint, upper_setpoint, upper_active,
                    input ready);
    modport sink   (input valid, lower_setpoint, upper_setpoint, upper_active,
                    output ready);
endinterface

`default_nettype wire

[hw/rtl/edsa_core.sv]
// Next-state logic for one poll sample: step, clamp, button toggle, push.
// Depends on edsa_pkg.
`default_nettype none

module edsa_core (
    input  edsa_pkg::cfg_t    cfg,
    input  edsa_pkg::sample_t smp,
    input  edsa_pkg::state_t  cur,
    output edsa_pkg::state_t  nxt
);
    import edsa_pkg::*;

    logic                      step_up;
    logic                      step_dn;
    logic                      press;
    logic [VALUE_W:0]          up_sum;
    logic [VALUE_W:0]          up_cnt;
    logic signed [VALUE_W+1:0] dn_cur;
    logic signed [VALUE_W+1:0] dn_min;
    logic signed [VALUE_W+1:0] dn_dif;
    logic signed [VALUE_W+1:0] dn_cnt;
    logic [VALUE_W-1:0]        stepped;
    logic [VALUE_W-1:0]        work;
    logic [VALUE_W:0]          push_up;

    always_comb
    begin
        step_up = !smp.line_a && smp.line_b && !cur.step_lockout;
        step_dn = smp.line_a && !smp.line_b && !cur.step_lockout;

        // up: add when below max, then clamp to max
        up_sum = {1'b0, cur.work_count} + {{(VALUE_W+1-STEP_W){1'b0}}, cfg.step_size};
        up_cnt = (cur.work_count < cfg.count_max) ? up_sum : {1'b0, cur.work_count};
        if (up_cnt > {1'b0, cfg.count_max})
            up_cnt = {1'b0, cfg.count_max};

        // down: signed, may dip below zero before the clamp
        dn_cur = $signed({2'b00, cur.work_count});
        dn_min = $signed({2'b00, cfg.count_min});
        dn_dif = dn_cur - $signed({{(VALUE_W+2-STEP_W){1'b0}}, cfg.step_size});
        dn_cnt = (dn_cur > dn_min) ? dn_dif : dn_cur;
        if (dn_cnt < dn_min)
            dn_cnt = dn_min;

        if (step_up)
            stepped = up_cnt[VALUE_W-1:0];
        else if (step_dn)
            stepped = dn_cnt[VALUE_W-1:0];
        else
            stepped = cur.work_count;

        nxt.step_lockout = (step_up || step_dn) ? 1'b1 : cur.step_lockout;
        if (smp.line_a && smp.line_b)
            nxt.step_lockout = 1'b0;

        press           = !smp.button_level && cur.button_prev;
        nxt.button_prev = smp.button_level;
        nxt.edit_upper  = cur.edit_upper ^ press;

        if (press)
            work = nxt.edit_upper ? cur.upper_value : cur.lower_value;
        else
            work = stepped;
        nxt.work_count = work;

        push_up = {1'b0, work} + {{(VALUE_W+1-GAP_W){1'b0}}, cfg.order_gap};

        nxt.lower_value = cur.lower_value;
        nxt.upper_value = cur.upper_value;
        if (nxt.edit_upper)
        begin
            nxt.upper_value = work;
            if (work <= cur.lower_value)
                nxt.lower_value = (work >= {{(VALUE_W-GAP_W){1'b0}}, cfg.order_gap})
                    ? work - {{(VALUE_W-GAP_W){1'b0}}, cfg.order_gap}
                    : '0;
        end
        else
        begin
            nxt.lower_value = work;
            if (work >= cur.upper_value)
                nxt.upper_value = push_up[VALUE_W] ? VALUE_MAX : push_up[VALUE_W-1:0];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/encoder_dual_setpoint_adjust.sv]
// Top level of the dual-setpoint encoder adjuster: config registers, input
// stage, state registers and result register. Depends on edsa_pkg, edsa_if, edsa_core.
`default_nettype none

// One poll transaction (encoder lines A/B and the active-low button) gives
// exactly one result transaction carrying both setpoints and which one is being
// edited. The block takes a transaction every cycle unless the result sink
// stalls it: the poll is captured in an input register, and once the result
// register is empty or being drained, edsa_core computes step, clamp,
// button toggle and the setpoint push in one short combinational pass whose
// outcome lands in the state registers and the result register together;
// throughput is one transaction per cycle, limited only by the result sink's
// ready. While a finished result waits, a new poll still lands in an empty
// input register; with both registers full, poll ready follows the sink's
// ready. Configuration (step_size, count_min, count_max, order_gap at indexes
// 0..3) is written through cfg_we/cfg_index/cfg_data and must only change
// while no transaction is in flight; writes to other indexes are dropped.
// There is no clearing pass: the block is ready right after reset.
module encoder_dual_setpoint_adjust (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [edsa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [edsa_pkg::CFG_DATA_W-1:0]  cfg_data,
    edsa_poll_if.sink                             poll,
    edsa_report_if.source                         report
);
    import edsa_pkg::*;

    cfg_t    cfg_reg;
    sample_t smp_reg;
    logic    smp_valid_reg;
    state_t  st_reg;
    state_t  st_next;
    logic    out_valid_reg;
    logic    s2_take;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_size <= RST_STEP_SIZE;
            cfg_reg.count_min <= RST_COUNT_MIN;
            cfg_reg.count_max <= RST_COUNT_MAX;
            cfg_reg.order_gap <= RST_ORDER_GAP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STEP_SIZE: cfg_reg.step_size <= cfg_data[STEP_W-1:0];
                REG_COUNT_MIN: cfg_reg.count_min <= cfg_data[VALUE_W-1:0];
                REG_COUNT_MAX: cfg_reg.count_max <= cfg_data[VALUE_W-1:0];
                REG_ORDER_GAP: cfg_reg.order_gap <= cfg_data[GAP_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 2 moves when the result register is empty or being drained
    assign s2_take    = smp_valid_reg && (!out_valid_reg || report.ready);
    assign poll.ready = !smp_valid_reg || s2_take;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            smp_valid_reg <= 1'b0;
        else if (poll.ready)
            smp_valid_reg <= poll.valid;
    end

    always_ff @(posedge clk)
    begin
        if (poll.valid && poll.ready)
        begin
            smp_reg.line_a       <= poll.line_a;
            smp_reg.line_b       <= poll.line_b;
            smp_reg.button_level <= poll.button_level;
        end
    end

    edsa_core u_core (
        .cfg (cfg_reg),
        .smp (smp_reg),
        .cur (st_reg),
        .nxt (st_next)
    );

    // block state, updated once per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.work_count   <= RST_WORK;
            st_reg.step_lockout <= 1'b0;
            st_reg.button_prev  <= 1'b1;
            st_reg.edit_upper   <= 1'b1;
            st_reg.lower_value  <= RST_LOWER;
            st_reg.upper_value  <= RST_UPPER;
        end
        else if (s2_take)
            st_reg <= st_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_take)
            out_valid_reg <= 1'b1;
        else if (report.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_take)
        begin
            report.lower_setpoint <= st_next.lower_value;
            report.upper_setpoint <= st_next.upper_value;
            report.upper_active   <= st_next.edit_upper;
        end
    end

    assign report.valid = out_valid_reg;

endmodule

`default_nettype wire

[hw/rtl/edsa_checker.sv]
// Port-level assertions for encoder_dual_setpoint_adjust and the bind that
// attaches them. Depends on edsa_pkg and the top level.
`default_nettype none

module edsa_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           poll_ready,
    input wire logic                           rep_valid,
    input wire logic                           rep_ready,
    input wire logic [edsa_pkg::VALUE_W-1:0]   rep_lower,
    input wire logic [edsa_pkg::VALUE_W-1:0]   rep_upper,
    input wire logic                           rep_active
);
    import edsa_pkg::*;

    // stalled result holds
    a_rep_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rep_valid && !rep_ready |=> rep_valid && $stable(rep_lower)
            && $stable(rep_upper) && $stable(rep_active))
        else $error("result changed while stalled");

    // setpoints never cross
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        rep_valid |-> rep_lower <= rep_upper)
        else $error("lower setpoint above upper setpoint");

    // empty result register means the poll side cannot be stalled
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !rep_valid |-> poll_ready)
        else $error("poll stalled with empty result register");

    // a result leaves the register only when taken
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(rep_valid) |-> $past(rep_ready))
        else $error("result dropped without handshake");

endmodule

bind encoder_dual_setpoint_adjust edsa_checker u_edsa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .poll_ready (poll.ready),
    .rep_valid  (report.valid),
    .rep_ready  (report.ready),
    .rep_lower  (report.lower_setpoint),
    .rep_upper  (report.upper_setpoint),
    .rep_active (report.upper_active)
);

`default_nettype wire

[sim/encoder_dual_setpoint_adjust_test.sv]
// Self-checking testbench for encoder_dual_setpoint_adjust: directed table, then
// randomized encoder detents and button presses under several register settings.
// Depends on edsa_pkg, edsa_if and the block's RTL.
`timescale 1ns / 1ps

module encoder_dual_setpoint_adjust_test;
    import edsa_pkg::*;

    // Run-length knobs
    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 5;
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 135;
    localparam int HOLD_CYCLES  = 120;      // long sink hold-off, fills the pipeline
    localparam int LINGER       = 8;
    localparam int CYCLE_LIMIT  = 400000;

    // A register index the block does not decode. 13 aliases to count_min on
    // a two-bit decode, so a sloppy decoder shows up in the next step.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd13;

    typedef struct packed {
        logic [VALUE_W-1:0] lower_setpoint;
        logic [VALUE_W-1:0] upper_setpoint;
        logic               upper_active;
    } setpoint_rpt_t;

    typedef enum logic {ROW_POLL, ROW_CFG} row_kind_t;

    // One line of the directed script. A poll row may carry a typed-in report;
    // otherwise the predictor supplies it. A cfg row is a register write.
    typedef struct {
        row_kind_t              kind;
        sample_t                smp;      // {line_a, line_b, button_level}
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        bit                     typed;
        setpoint_rpt_t          want;
    } row_t;

    localparam setpoint_rpt_t NO_RPT = '0;
    localparam int SCRIPT_LEN = 27;

    // Reset config is step 5, min 5, max 295, gap 5; setpoints 200/250, upper
    // active, working count 250.
    row_t script [SCRIPT_LEN] = '{
        // idle lines right after reset
        '{ROW_POLL, 3'b111, REG_STEP_SIZE, 9'd0,   1'b1, '{9'd200, 9'd250, 1'b1}},
        '{ROW_POLL, 3'b011, REG_STEP_SIZE, 9'd0,   1'b0, NO_RPT},  // up step
        '{ROW_POLL, 3'b011, REG_STEP_SIZE, 9'd0,   1'b0, NO_RPT},  // locked out
        '{ROW_POLL, 3'b001, REG_STEP_SIZE, 9'd0,   1'b0, NO_RPT},  // both low, lock kept
        '{ROW_POLL, 3'b101, REG_STEP_SIZE, 9'd0,   1'b0, NO_RPT},  // down, still locked
        '{ROW_POLL, 3'b111, REG_STEP_SIZE, 9'd0,   1'b0, NO_RPT},  // release
        '{ROW_POLL, 3'b101, REG_STEP_SIZE, 9'd0,   1'b0, NO_RPT},  // down step
        '{ROW_CFG,  3'b111, REG_ORDER_GAP, 9'd31,  1'b0, NO_RPT},
        '{ROW_CFG,  3'b111, REG_COUNT_MIN, 9'd511, 1'b0, NO_RPT},  // min above max
        '{ROW_POLL, 3'b110, REG_STEP_SIZE, 9'd0,   1'b0, NO_RPT},  // press: edit lower
        // down step jumps to count_min = 511, upper push saturates
        '{ROW_POLL, 3'b100, REG_STEP_SIZE, 9'd0,   1'b1, '{9'd511, 9'd511, 1'b0}},
        '{ROW_POLL, 3'b111, REG_STEP_SIZE, 9'd0,   1'b0, NO_RPT},
        '{ROW_POLL, 3'b011, REG_STEP_SIZE, 9'd0,   1'b0, NO_RPT},  // above max, up step
        '{ROW_CFG,  3'b111, REG_COUNT_MIN, 9'd0,   1'b0, NO_RPT},
        '{ROW_POLL, 3'b110, REG_STEP_SIZE, 9'd0,   1'b0, NO_RPT},  // loads 511 > max
        '{ROW_POLL, 3'b101, REG_STEP_SIZE, 9'd0,   1'b0, NO_RPT},
        '{ROW_POLL, 3'b111, REG_STEP_SIZE, 9'd0,   1'b0, NO_RPT},
        '{ROW_CFG,  3'b111, REG_STEP_SIZE, 9'd0,   1'b0, NO_RPT},  // zero step
        '{ROW_POLL, 3'b011, REG_STEP_SIZE, 9'd0,   1'b0, NO_RPT},
        '{ROW_POLL, 3'b111, REG_STEP_SIZE, 9'd0,   1'b0, NO_RPT},
        '{ROW_POLL, 3'b011, REG_STEP_SIZE, 9'd0,   1'b0, NO_RPT},
        '{ROW_CFG,  3'b111, REG_STEP_SIZE, 9'd31,  1'b0, NO_RPT},
        '{ROW_CFG,  3'b111, REG_COUNT_MAX, 9'd0,   1'b0, NO_RPT},
        '{ROW_POLL, 3'b111, REG_STEP_SIZE, 9'd0,   1'b0, NO_RPT},
        // up step clamps to max 0, lower push saturates at 0
        '{ROW_POLL, 3'b011, REG_STEP_SIZE, 9'd0,   1'b1, '{9'd0, 9'd0, 1'b1}},
        '{ROW_CFG,  3'b111, REG_UNUSED,    9'd100, 1'b0, NO_RPT},  // must be dropped
        '{ROW_POLL, 3'b101, REG_STEP_SIZE, 9'd0,   1'b0, NO_RPT}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    edsa_poll_if   poll_ch ();
    edsa_report_if report_ch ();

    encoder_dual_setpoint_adjust u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .poll      (poll_ch),
        .report    (report_ch)
    );

    always #CLK_HALF clk = ~clk;

    // Predictor state: a shadow of the registers and of the adjuster itself.
    cfg_t          reg_shadow;
    state_t        knob_state;
    setpoint_rpt_t pending_reports [$];

    int unsigned items_total;
    int unsigned settings_count;
    int unsigned rx_count;
    int unsigned mismatches;
    int unsigned watchdog_cycles;

    // Mostly back-to-back, sometimes a few cycles, rarely a long gap.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(99, 0);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(3, 1);
        else if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(40, 16);
    endfunction

    // One poll sample through the adjuster: step, clamp, lockout, button
    // toggle, then write the count into the active setpoint and push the other.
    function automatic setpoint_rpt_t advance_setpoints(sample_t s);
        int            cnt;
        int            cmin;
        int            cmax;
        int            sum;
        setpoint_rpt_t r;
        cnt  = int'(knob_state.work_count);
        cmin = int'(reg_shadow.count_min);
        cmax = int'(reg_shadow.count_max);
        if (!s.line_a && s.line_b && !knob_state.step_lockout)
        begin
            if (cnt < cmax)
                cnt += int'(reg_shadow.step_size);
            if (cnt > cmax)
                cnt = cmax;
            knob_state.step_lockout = 1'b1;
        end
        if (s.line_a && !s.line_b && !knob_state.step_lockout)
        begin
            if (cnt > cmin)
                cnt -= int'(reg_shadow.step_size);
            if (cnt < cmin)
                cnt = cmin;
            knob_state.step_lockout = 1'b1;
        end
        if (s.line_a && s.line_b)
            knob_state.step_lockout = 1'b0;

        if (!s.button_level && knob_state.button_prev)
        begin
            knob_state.edit_upper = !knob_state.edit_upper;
            cnt = knob_state.edit_upper ? int'(knob_state.upper_value)
                                        : int'(knob_state.lower_value);
        end
        knob_state.button_prev = s.button_level;
        knob_state.work_count  = cnt[VALUE_W-1:0];

        if (knob_state.edit_upper)
        begin
            knob_state.upper_value = knob_state.work_count;
            if (knob_state.upper_value <= knob_state.lower_value)
                knob_state.lower_value = (knob_state.upper_value >= reg_shadow.order_gap) ?
                    knob_state.upper_value - reg_shadow.order_gap : '0;
        end
        else
        begin
            knob_state.lower_value = knob_state.work_count;
            if (knob_state.lower_value >= knob_state.upper_value)
            begin
                sum = int'(knob_state.lower_value) + int'(reg_shadow.order_gap);
                knob_state.upper_value = (sum > int'(VALUE_MAX)) ? VALUE_MAX
                                                                 : sum[VALUE_W-1:0];
            end
        end

        r.lower_setpoint = knob_state.lower_value;
        r.upper_setpoint = knob_state.upper_value;
        r.upper_active   = knob_state.edit_upper;
        return r;
    endfunction

    // Offer one poll transaction and wait for it to be taken. Valid is only
    // dropped when a gap follows, so back-to-back items never see a 0/1 pair
    // scheduled in the same step. Every 160 items, a calm stretch of 32 goes
    // without gaps.
    task automatic send_poll(input sample_t s, input bit typed, input setpoint_rpt_t want);
        int            gap;
        setpoint_rpt_t predicted;
        gap = ((items_total % 160) >= 128) ? 0 : idle_cycles();
        if (gap > 0)
        begin
            poll_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        poll_ch.valid        <= 1'b1;
        poll_ch.line_a       <= s.line_a;
        poll_ch.line_b       <= s.line_b;
        poll_ch.button_level <= s.button_level;
        do
            @(posedge clk);
        while (!poll_ch.ready);
        predicted = advance_setpoints(s);
        pending_reports.push_back(typed ? want : predicted);
        items_total++;
    endtask

    // Stop offering and let every outstanding report come back, so register
    // writes only land while nothing is in flight.
    task automatic settle();
        poll_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    // The enable is raised, held over a clock edge and then lowered, so it never rises and falls in one step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_STEP_SIZE: reg_shadow.step_size = data[STEP_W-1:0];
            REG_COUNT_MIN: reg_shadow.count_min = data[VALUE_W-1:0];
            REG_COUNT_MAX: reg_shadow.count_max = data[VALUE_W-1:0];
            REG_ORDER_GAP: reg_shadow.order_gap = data[GAP_W-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Report sink: checks each report transaction against the oldest
    // expectation and drives ready with random stalls. Two long hold-offs
    // are counted here while the source keeps offering polls.
    initial
    begin
        setpoint_rpt_t exp_rpt;
        int unsigned   stall_left;
        int unsigned   rx_cycle;
        logic          rdy;
        report_ch.ready = 1'b0;
        rx_count        = 0;
        mismatches      = 0;
        stall_left      = 0;
        rx_cycle        = 0;
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (report_ch.valid && report_ch.ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    $error("report transaction with nothing expected: lower=%0d upper=%0d active=%0d",
                           report_ch.lower_setpoint, report_ch.upper_setpoint,
                           report_ch.upper_active);
                    mismatches++;
                end
                else
                begin
                    exp_rpt = pending_reports.pop_front();
                    if (report_ch.lower_setpoint !== exp_rpt.lower_setpoint)
                    begin
                        $error("lower_setpoint: expected %0d, got %0d",
                               exp_rpt.lower_setpoint, report_ch.lower_setpoint);
                        mismatches++;
                    end
                    if (report_ch.upper_setpoint !== exp_rpt.upper_setpoint)
                    begin
                        $error("upper_setpoint: expected %0d, got %0d",
                               exp_rpt.upper_setpoint, report_ch.upper_setpoint);
                        mismatches++;
                    end
                    if (report_ch.upper_active !== exp_rpt.upper_active)
                    begin
                        $error("upper_active: expected %0d, got %0d",
                               exp_rpt.upper_active, report_ch.upper_active);
                        mismatches++;
                    end
                end
                rx_count++;
                if (rx_count == 300 || rx_count == 800)
                    stall_left = HOLD_CYCLES;
            end

            if (stall_left > 0)
            begin
                rdy = 1'b0;
                stall_left--;
            end
            else
            begin
                rdy = 1'b1;
                // calm stretch: no random stalls while rx_cycle % 256 is below 48
                if ((rx_cycle % 256) >= 48 && $urandom_range(99, 0) < 25)
                    stall_left = idle_cycles();
            end
            report_ch.ready <= rdy;
        end
    end

    // Watchdog
    initial
    begin
        watchdog_cycles = 0;
        while (watchdog_cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            watchdog_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stimulus: reset, directed script, then randomized phases.
    initial
    begin
        sample_t              smp;
        logic                 btn_lvl;
        logic                 turn_up;
        logic                 ea;
        logic                 eb;
        int                   run_left;
        int                   phase_end;
        int                   reps;
        logic [CFG_DATA_W-1:0] step_d;
        logic [CFG_DATA_W-1:0] min_d;
        logic [CFG_DATA_W-1:0] max_d;
        logic [CFG_DATA_W-1:0] gap_d;

        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = REG_STEP_SIZE;
        cfg_data             = '0;
        poll_ch.valid        = 1'b0;
        poll_ch.line_a       = 1'b1;
        poll_ch.line_b       = 1'b1;
        poll_ch.button_level = 1'b1;

        reg_shadow.step_size    = RST_STEP_SIZE;
        reg_shadow.count_min    = RST_COUNT_MIN;
        reg_shadow.count_max    = RST_COUNT_MAX;
        reg_shadow.order_gap    = RST_ORDER_GAP;
        knob_state.work_count   = RST_WORK;
        knob_state.step_lockout = 1'b0;
        knob_state.button_prev  = 1'b1;
        knob_state.edit_upper   = 1'b1;
        knob_state.lower_value  = RST_LOWER;
        knob_state.upper_value  = RST_UPPER;

        items_total    = 0;
        settings_count = 1;
        btn_lvl        = 1'b1;
        run_left       = 0;
        turn_up        = 1'b1;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: extremes, lockout, button toggles, clamps, saturation.
        foreach (script[i])
        begin
            if (script[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(script[i].idx, script[i].data);
                settings_count++;
            end
            else
                send_poll(script[i].smp, script[i].typed, script[i].want);
        end

        // Random part. Each phase programs all four registers, then runs
        // mostly clean quadrature detents (in runs of one direction, with
        // occasional repeated polls and slow button presses), plus bursts
        // of arbitrary line noise.
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            settle();
            if ($urandom_range(1, 0))
                write_reg(4'($urandom_range(2**CFG_IDX_W - 1, REG_ORDER_GAP + 1)),
                          9'($urandom_range(511, 0)));
            case (ph)
                0:
                begin
                    step_d = CFG_DATA_W'(RST_STEP_SIZE);
                    min_d  = RST_COUNT_MIN;
                    max_d  = RST_COUNT_MAX;
                    gap_d  = CFG_DATA_W'(RST_ORDER_GAP);
                end
                1:
                begin
                    // widest range, biggest step and gap: saturating pushes
                    step_d = 9'd31;
                    min_d  = 9'd0;
                    max_d  = VALUE_MAX;
                    gap_d  = 9'd31;
                end
                2:
                begin
                    step_d = 9'd1;
                    min_d  = 9'd0;
                    max_d  = VALUE_MAX;
                    gap_d  = 9'd0;
                end
                3:
                begin
                    // zero step, upper data bits set to check the masking
                    step_d = 9'h1E0;
                    min_d  = 9'($urandom_range(150, 0));
                    max_d  = 9'($urandom_range(511, 300));
                    gap_d  = 9'($urandom_range(511, 0));
                end
                4:
                begin
                    // inverted limits
                    step_d = 9'($urandom_range(511, 0));
                    min_d  = 9'($urandom_range(511, 300));
                    max_d  = 9'($urandom_range(200, 0));
                    gap_d  = 9'($urandom_range(511, 0));
                end
                default:
                begin
                    step_d = 9'($urandom_range(511, 0));
                    min_d  = 9'($urandom_range(511, 0));
                    max_d  = 9'($urandom_range(511, 0));
                    gap_d  = 9'($urandom_range(511, 0));
                end
            endcase
            write_reg(REG_STEP_SIZE, step_d);
            write_reg(REG_COUNT_MIN, min_d);
            write_reg(REG_COUNT_MAX, max_d);
            write_reg(REG_ORDER_GAP, gap_d);
            settings_count++;

            phase_end = items_total + PHASE_ITEMS;
            while (items_total < phase_end)
            begin
                if ($urandom_range(99, 0) < 85)
                begin
                    if (run_left == 0)
                    begin
                        run_left = $urandom_range(12, 1);
                        turn_up  = 1'($urandom_range(1, 0));
                    end
                    run_left--;
                    // up detent, A leads: (A,B) = 01, 00, 10, 11; down swaps A and B
                    for (int k = 0; k < 4; k++)
                    begin
                        if ($urandom_range(99, 0) < 4)
                            btn_lvl = ~btn_lvl;
                        ea = (k >= 2);
                        eb = (k == 0 || k == 3);
                        smp.line_a       = turn_up ? ea : eb;
                        smp.line_b       = turn_up ? eb : ea;
                        smp.button_level = btn_lvl;
                        reps = ($urandom_range(99, 0) < 25) ? 2 : 1;
                        repeat (reps) send_poll(smp, 1'b0, NO_RPT);
                    end
                end
                else
                begin
                    repeat ($urandom_range(4, 1))
                    begin
                        smp = sample_t'(3'($urandom_range(7, 0)));
                        send_poll(smp, 1'b0, NO_RPT);
                    end
                end
            end
        end

        settle();
        repeat (LINGER) @(posedge clk);

        $display("Sent %0d poll transactions under %0d register settings;", items_total,
                 settings_count);
        $display("checked %0d report transactions, %0d mismatches.", rx_count, mismatches);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
